[design/tkl_pkg.sv]
// Package for the sorted top-K insertion list.
// Holds operation codes, field widths, the cell control struct and the tag filler.
// No dependencies.
package tkl_pkg;

  localparam int SCORE_W        = 64;
  localparam int TAG_W          = 24;
  localparam int OP_W           = 2;
  localparam int SLOT_W         = 4;
  localparam int POS_W          = 4;
  localparam int COUNT_W        = 5;
  localparam int DEF_LIST_DEPTH = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [7:0]       SPACE_CHAR = 8'h20;
  localparam logic [TAG_W-1:0] SPACE_TAG  = 24'h202020;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // qualifying insert this cycle
    logic clear;   // return to reset contents
  } cell_ctl_t;

  // Each zero byte of a tag is stored as a space.
  function automatic logic [TAG_W-1:0] fill_spaces(input logic [TAG_W-1:0] raw);
    logic [TAG_W-1:0] res;
    res = raw;
    for (int b = 0; b < 3; b++) begin
      if (raw[8*b +: 8] == 8'h00) begin
        res[8*b +: 8] = SPACE_CHAR;
      end
    end
    return res;
  endfunction

endpackage

[design/tkl_cell.sv]
// One slot of the sorted list: holds a score and a tag.
// Clears, takes the new entry, takes its upper neighbor's entry, or holds. Depends on tkl_pkg.
module tkl_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkl_pkg::cell_ctl_t          ctl,
  input  logic [tkl_pkg::SCORE_W-1:0] new_score,
  input  logic [tkl_pkg::TAG_W-1:0]   new_tag,
  input  logic                        in_range,
  input  logic                        ge_prev,
  input  logic [tkl_pkg::SCORE_W-1:0] prev_score,
  input  logic [tkl_pkg::TAG_W-1:0]   prev_tag,
  output logic                        ge_out,
  output logic                        hit,
  output logic [tkl_pkg::SCORE_W-1:0] score,
  output logic [tkl_pkg::TAG_W-1:0]   tag
);
  import tkl_pkg::*;

  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic               local_ge;

  // The new entry passes this slot while the stored score is equal or higher.
  assign local_ge = in_range && (new_score <= score_r);
  assign ge_out   = ge_prev && local_ge;
  assign hit      = ge_prev && !local_ge;

  always_comb begin
    score_nxt = score_r;
    tag_nxt   = tag_r;
    priority if (ctl.clear) begin
      score_nxt = '0;
      tag_nxt   = SPACE_TAG;
    end else if (ctl.insert && hit) begin
      score_nxt = new_score;
      tag_nxt   = new_tag;
    end else if (ctl.insert && !ge_prev) begin
      score_nxt = prev_score;
      tag_nxt   = prev_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      tag_r   <= SPACE_TAG;
    end else begin
      score_r <= score_nxt;
      tag_r   <= tag_nxt;
    end
  end

  assign score = score_r;
  assign tag   = tag_r;

endmodule

[design/top_k_sorted_insert_list_core.sv]
// The result strobe rises in the cycle after the request is taken.
// Throughput: one request per cycle; every slot compares and shifts in parallel
// along the cell chain, so busy stays low.
// Reset (synchronous, rst_n low): count zero, all slots score 0 with a tag of spaces.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Depends on tkl_pkg and tkl_cell.
module top_k_sorted_insert_list_core #(
  parameter int LIST_DEPTH = tkl_pkg::DEF_LIST_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tkl_pkg::OP_W-1:0]    in_operation,
  input  logic [tkl_pkg::SCORE_W-1:0] in_score,
  input  logic [tkl_pkg::TAG_W-1:0]   in_tag,
  input  logic [tkl_pkg::SLOT_W-1:0]  in_slot_index,
  output logic                        out_valid,
  output logic                        out_accepted,
  output logic [tkl_pkg::POS_W-1:0]   out_position,
  output logic [tkl_pkg::COUNT_W-1:0] out_entry_count,
  output logic [tkl_pkg::SCORE_W-1:0] out_read_score,
  output logic [tkl_pkg::TAG_W-1:0]   out_read_tag
);
  import tkl_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [CW-1:0]      count_r, count_nxt, limit;
  logic               full, qualify, is_insert;
  cell_ctl_t          ctl;
  logic [TAG_W-1:0]   filled_tag;
  logic [LIST_DEPTH:0] ge_chain;
  logic [LIST_DEPTH-1:0] hit, in_range;
  logic [SCORE_W-1:0] cell_score [LIST_DEPTH];
  logic [TAG_W-1:0]   cell_tag [LIST_DEPTH];
  logic [PW-1:0]      at;
  logic [SCORE_W-1:0] rd_score;
  logic [TAG_W-1:0]   rd_tag;

  logic               valid_r, accepted_r;
  logic [POS_W-1:0]   position_r;
  logic [COUNT_W-1:0] entry_count_r;
  logic [SCORE_W-1:0] read_score_r;
  logic [TAG_W-1:0]   read_tag_r;

  // No request is ever held off.
  assign busy = 1'b0;

  assign full       = (count_r >= CW'(LIST_DEPTH));
  assign is_insert  = start && (in_operation == OP_INSERT);
  assign qualify    = is_insert && (!full || (in_score > cell_score[LIST_DEPTH-1]));
  assign limit      = full ? CW'(LIST_DEPTH - 1) : count_r;
  assign filled_tag = fill_spaces(in_tag);
  assign ctl.insert = qualify;
  assign ctl.clear  = start && (in_operation == OP_CLEAR);

  assign ge_chain[0] = 1'b1;

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    assign in_range[k] = (CW'(k) < limit);
    tkl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_score  (in_score),
      .new_tag    (filled_tag),
      .in_range   (in_range[k]),
      .ge_prev    (ge_chain[k]),
      .prev_score ((k == 0) ? in_score : cell_score[(k == 0) ? 0 : k-1]),
      .prev_tag   ((k == 0) ? filled_tag : cell_tag[(k == 0) ? 0 : k-1]),
      .ge_out     (ge_chain[k+1]),
      .hit        (hit[k]),
      .score      (cell_score[k]),
      .tag        (cell_tag[k])
    );
  end

  // Landing slot and read selection, each an OR over one-hot matches.
  always_comb begin
    at       = '0;
    rd_score = '0;
    rd_tag   = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (hit[k]) begin
        at = at | PW'(k);
      end
      if (int'(in_slot_index) == k) begin
        rd_score = rd_score | cell_score[k];
        rd_tag   = rd_tag | cell_tag[k];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    priority if (ctl.clear) begin
      count_nxt = '0;
    end else if (qualify && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    accepted_r    <= qualify;
    position_r    <= qualify ? POS_W'(at) : '0;
    entry_count_r <= COUNT_W'(count_nxt);
    if (start && (in_operation == OP_READ)) begin
      read_score_r <= rd_score;
      read_tag_r   <= rd_tag;
    end else begin
      read_score_r <= '0;
      read_tag_r   <= '0;
    end
  end

  assign out_valid       = valid_r;
  assign out_accepted    = accepted_r;
  assign out_position    = position_r;
  assign out_entry_count = entry_count_r;
  assign out_read_score  = read_score_r;
  assign out_read_tag    = read_tag_r;

endmodule
